>>> rtl/pbm_pkg.sv
// Shared types and constants of the pipelined Booth multiplier unit.
`timescale 1ns / 1ps

package pbm_pkg;

  localparam int OP_W       = 32;
  localparam int PROD_W     = 64;
  localparam int ROW_COUNT  = 19;
  localparam int DIGIT_ROWS = 16;
  localparam int FIX_ROW_A  = 16;
  localparam int FIX_ROW_B  = 17;
  localparam int NEG_ROW    = 18;

  // Multiply kinds.
  localparam logic [1:0] KIND_MUL    = 2'b00;
  localparam logic [1:0] KIND_MULH   = 2'b01;
  localparam logic [1:0] KIND_MULHSU = 2'b10;
  localparam logic [1:0] KIND_MULHU  = 2'b11;

  // Radix-4 Booth windows of the multiplier.
  localparam logic [2:0] BW_ZERO_P = 3'b000;
  localparam logic [2:0] BW_ONE_A  = 3'b001;
  localparam logic [2:0] BW_ONE_B  = 3'b010;
  localparam logic [2:0] BW_TWO    = 3'b011;
  localparam logic [2:0] BW_MTWO   = 3'b100;
  localparam logic [2:0] BW_MONE_A = 3'b101;
  localparam logic [2:0] BW_MONE_B = 3'b110;
  localparam logic [2:0] BW_ZERO_N = 3'b111;

  typedef logic [PROD_W-1:0] row_t;
  typedef row_t [ROW_COUNT-1:0] rows_t;

endpackage

>>> rtl/pbm_booth_rows.sv
// Radix-4 Booth partial product rows with fixup and negation rows.
`timescale 1ns / 1ps

module pbm_booth_rows
  import pbm_pkg::*;
(
  input  logic [OP_W-1:0] a,
  input  logic [OP_W-1:0] b,
  input  logic [1:0]      kind,
  output rows_t           rows
);

  logic [PROD_W-1:0] ax;
  logic [OP_W:0]     b_ext;

  assign ax    = {{(PROD_W - OP_W){a[OP_W-1]}}, a};
  assign b_ext = {b, 1'b0};

  always_comb begin
    logic [2:0]        win;
    logic [PROD_W-1:0] r;
    logic [PROD_W-1:0] negbits;
    logic              neg;
    negbits = '0;
    rows    = '0;
    for (int i = 0; i < DIGIT_ROWS; i++) begin
      win = b_ext[2*i +: 3];
      r   = '0;
      neg = 1'b0;
      unique case (win)
        BW_ONE_A, BW_ONE_B:   r = ax;
        BW_TWO:               r = ax << 1;
        BW_MTWO: begin
          r   = ~(ax << 1);
          neg = 1'b1;
        end
        BW_MONE_A, BW_MONE_B: begin
          r   = ~ax;
          neg = 1'b1;
        end
        BW_ZERO_P, BW_ZERO_N: r = '0;
      endcase
      negbits[2*i] = neg;
      rows[i]      = r << (2 * i);
    end
    // Unsigned forms add back the terms that the signed reading removed.
    rows[FIX_ROW_A] = (kind == KIND_MULHU && a[OP_W-1]) ?
                      {b, {OP_W{1'b0}}} : '0;
    rows[FIX_ROW_B] = ((kind == KIND_MULHU || kind == KIND_MULHSU) && b[OP_W-1]) ?
                      {ax[OP_W-1:0], {OP_W{1'b0}}} : '0;
    rows[NEG_ROW]   = negbits;
  end

endmodule

>>> rtl/pbm_csa_tree.sv
// Carry-save reduction of the 19 partial product rows to a sum and carry pair.
`timescale 1ns / 1ps

module pbm_csa_tree
  import pbm_pkg::*;
(
  input  rows_t             rows,
  output logic [PROD_W-1:0] sum,
  output logic [PROD_W-1:0] carry
);

  typedef struct packed {
    logic [PROD_W-1:0] s;
    logic [PROD_W-1:0] c;
  } csa_t;

  function automatic csa_t add3(input logic [PROD_W-1:0] x, input logic [PROD_W-1:0] y,
                                input logic [PROD_W-1:0] z);
    csa_t res;
    res.s = x ^ y ^ z;
    res.c = ((x & y) | (x & z) | (y & z)) << 1;
    return res;
  endfunction

  csa_t l0 [6];
  csa_t l1 [4];
  csa_t l2 [3];
  csa_t l3 [2];
  csa_t l4;
  csa_t l5;

  always_comb begin
    for (int g = 0; g < 6; g++) begin
      l0[g] = add3(rows[3*g], rows[3*g+1], rows[3*g+2]);
    end
  end

  assign l1[0] = add3(l0[0].s, l0[0].c, l0[1].s);
  assign l1[1] = add3(l0[1].c, l0[2].s, l0[2].c);
  assign l1[2] = add3(l0[3].s, l0[3].c, l0[4].s);
  assign l1[3] = add3(l0[4].c, l0[5].s, l0[5].c);
  assign l2[0] = add3(l1[0].s, l1[0].c, l1[1].s);
  assign l2[1] = add3(l1[1].c, l1[2].s, l1[2].c);
  assign l2[2] = add3(l1[3].s, l1[3].c, rows[NEG_ROW]);
  assign l3[0] = add3(l2[0].s, l2[0].c, l2[1].s);
  assign l3[1] = add3(l2[1].c, l2[2].s, l2[2].c);
  assign l4    = add3(l3[0].s, l3[0].c, l3[1].s);
  assign l5    = add3(l4.s, l4.c, l3[1].c);

  assign sum   = l5.s;
  assign carry = l5.c;

endmodule

>>> rtl/pipelined_booth_multiplier_unit.sv
// Top level of the pipelined Booth multiplier unit with its result buffer.
`timescale 1ns / 1ps

// Usage: every request on the slave stream is one clock of a three-stage
// multiply unit. A request carries an optional dispatch (kind, operands, tag),
// an optional squash bound and an optional grant that frees a result slot.
// Applying it moves the Booth stage into the carry-save stage, the
// carry-save stage through the final adder into the first free result slot,
// and loads the new dispatch into the Booth stage. Squash kills every stage
// and slot whose tag is not older than the squash tag (wrap-aware compare).
// A finished result that meets a full buffer is dropped.
// For each request exactly one status word goes out on the master stream:
// the oldest valid slot (valid, value, tag) and the full and empty flags,
// all as they stand after that request.
// The status word is loaded into the output register from the scan stage; the
// buffer state is read in the cycle after the request is applied.
// Throughput: one request per cycle unless the receiver stalls; the state update
// and the oldest-slot scan each sit between registers, so requests flow back to back.
// Reset clears the stage valid bits, all slot valid bits and both stream
// stages. When the receiver stalls, one status word waits in the output
// register and one more in the scan stage; then tready drops and the unit
// state holds until the receiver takes the waiting word.

module pipelined_booth_multiplier_unit
  import pbm_pkg::*;
#(
  parameter int RESULT_SLOTS = 4,
  parameter int TAG_BITS     = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: dispatch_valid, mul_kind[2], operand_a[32], operand_b[32],
  // dispatch_tag[5], squash_valid, squash_tag[5], grant_valid, grant_tag[5], zero pad.
  input  logic [87:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: head_valid, head_value[32], head_tag[5], buffer_full,
  // buffer_empty.
  output logic [39:0] m_axis_tdata
);

  localparam int SLOT_IDX_W = $clog2(RESULT_SLOTS);

  typedef logic [TAG_BITS-1:0] tag_t;

  function automatic logic older(input tag_t x, input tag_t y);
    tag_t d;
    d = x - y;
    return d[TAG_BITS-1];
  endfunction

  // Request fields.
  logic            dispatch_valid;
  logic [1:0]      mul_kind;
  logic [OP_W-1:0] operand_a;
  logic [OP_W-1:0] operand_b;
  tag_t            dispatch_tag;
  logic            squash_valid;
  tag_t            squash_tag;
  logic            grant_valid;
  tag_t            grant_tag;

  assign dispatch_valid = s_axis_tdata[0];
  assign mul_kind       = s_axis_tdata[2:1];
  assign operand_a      = s_axis_tdata[34:3];
  assign operand_b      = s_axis_tdata[66:35];
  assign dispatch_tag   = TAG_BITS'(s_axis_tdata[71:67]);
  assign squash_valid   = s_axis_tdata[72];
  assign squash_tag     = TAG_BITS'(s_axis_tdata[77:73]);
  assign grant_valid    = s_axis_tdata[78];
  assign grant_tag      = TAG_BITS'(s_axis_tdata[83:79]);

  // Pipeline and buffer state.
  logic                    booth_valid;
  rows_t                   booth_rows;
  logic [1:0]              booth_kind;
  tag_t                    booth_tag;
  logic                    tree_valid;
  logic [PROD_W-1:0]       tree_sum;
  logic [PROD_W-1:0]       tree_carry;
  logic [1:0]              tree_kind;
  tag_t                    tree_tag;
  logic [RESULT_SLOTS-1:0] slot_valid;
  tag_t                    slot_tag   [RESULT_SLOTS];
  logic [OP_W-1:0]         slot_value [RESULT_SLOTS];

  // Stream control: a scan stage and an output register.
  logic        pending;
  logic        out_can_load;
  logic        step;
  logic [39:0] out_data;

  assign out_can_load  = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = out_can_load || !pending;
  assign step          = s_axis_tvalid && s_axis_tready;

  // Stage datapaths.
  rows_t             new_rows;
  logic [PROD_W-1:0] red_sum;
  logic [PROD_W-1:0] red_carry;

  pbm_booth_rows u_rows (
    .a    (operand_a),
    .b    (operand_b),
    .kind (mul_kind),
    .rows (new_rows)
  );

  pbm_csa_tree u_tree (
    .rows  (booth_rows),
    .sum   (red_sum),
    .carry (red_carry)
  );

  logic [PROD_W-1:0] product;
  logic [OP_W-1:0]   result;

  assign product = tree_sum + tree_carry;
  assign result  = (tree_kind == KIND_MUL) ? product[OP_W-1:0] : product[PROD_W-1:OP_W];

  // Slot update: grants free matching slots, the first free slot takes the
  // finished result, and a squash kills slots that are not older than its tag.
  logic [RESULT_SLOTS-1:0] freed;
  logic [RESULT_SLOTS-1:0] fill_hit;
  logic [RESULT_SLOTS-1:0] slot_valid_next;
  logic                    fill_keep;

  assign fill_keep = !(squash_valid && !older(tree_tag, squash_tag));

  always_comb begin
    logic taken;
    logic killed;
    taken = 1'b0;
    for (int i = 0; i < RESULT_SLOTS; i++) begin
      freed[i]    = grant_valid && slot_valid[i] && (slot_tag[i] == grant_tag);
      fill_hit[i] = tree_valid && !taken && (!slot_valid[i] || freed[i]);
      if (fill_hit[i]) begin
        taken = 1'b1;
      end
      killed = squash_valid && slot_valid[i] && !older(slot_tag[i], squash_tag);
      slot_valid_next[i] = fill_hit[i] ? fill_keep : (slot_valid[i] && !freed[i] && !killed);
    end
  end

  logic tree_valid_next;
  logic booth_valid_next;

  assign tree_valid_next  = booth_valid && !(squash_valid && !older(booth_tag, squash_tag));
  assign booth_valid_next = dispatch_valid &&
                            !(squash_valid && !older(dispatch_tag, squash_tag));

  always @(posedge clk) begin
    if (rst) begin
      booth_valid <= 1'b0;
      tree_valid  <= 1'b0;
      slot_valid  <= '0;
    end else if (step) begin
      booth_valid <= booth_valid_next;
      tree_valid  <= tree_valid_next;
      slot_valid  <= slot_valid_next;
    end
  end

  always @(posedge clk) begin
    if (step) begin
      if (dispatch_valid) begin
        booth_rows <= new_rows;
        booth_kind <= mul_kind;
        booth_tag  <= dispatch_tag;
      end
      if (booth_valid) begin
        tree_sum   <= red_sum;
        tree_carry <= red_carry;
        tree_kind  <= booth_kind;
        tree_tag   <= booth_tag;
      end
      for (int i = 0; i < RESULT_SLOTS; i++) begin
        if (fill_hit[i]) begin
          slot_tag[i]   <= tree_tag;
          slot_value[i] <= result;
        end
      end
    end
  end

  // Oldest-slot scan over the buffer as left by the last applied request.
  logic [SLOT_IDX_W-1:0] best_idx;
  logic                  best_found;
  logic                  buffer_full;
  logic                  buffer_empty;

  always_comb begin
    tag_t best_tag;
    best_idx   = '0;
    best_found = 1'b0;
    best_tag   = '0;
    for (int i = 0; i < RESULT_SLOTS; i++) begin
      if (slot_valid[i] && (!best_found || older(slot_tag[i], best_tag))) begin
        best_idx   = SLOT_IDX_W'(i);
        best_tag   = slot_tag[i];
        best_found = 1'b1;
      end
    end
  end

  assign buffer_full  = &slot_valid;
  assign buffer_empty = ~|slot_valid;

  assign out_data = {buffer_empty,
                     buffer_full,
                     best_found ? 5'(slot_tag[best_idx]) : 5'd0,
                     best_found ? slot_value[best_idx] : {OP_W{1'b0}},
                     best_found};

  always @(posedge clk) begin
    if (rst) begin
      pending       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (step) begin
        pending <= 1'b1;
      end else if (out_can_load) begin
        pending <= 1'b0;
      end
      if (out_can_load) begin
        m_axis_tvalid <= pending;
      end
    end
  end

  always @(posedge clk) begin
    if (out_can_load && pending) begin
      m_axis_tdata <= out_data;
    end
  end

endmodule
